### hw/rtl/fdr_pkg.sv
`timescale 1ns / 1ps
// fdr_pkg: shared widths and constants of the fresnel reflectance pipeline
// used by the divider, the square root and the top level; depends on nothing

package fdr_pkg;

	// fixed-point one in the q.30 cosine domain
	localparam int unsigned ONE_Q30_W = 31;
	localparam logic [ONE_Q30_W-1:0] ONE_Q30 = 31'h4000_0000;

	// transmitted cosine squared division: 32 bit divisor, 31 quotient bits
	localparam int unsigned DCOS_DEN_W = 32;
	localparam int unsigned DCOS_Q_W   = 31;

	// square root of a q.60 radicand, 31 result bits
	localparam int unsigned SQRT_W = 31;

	// amplitude ratio division: 38 bit divisor, q.26 quotient
	localparam int unsigned AMP_DEN_W = 38;
	localparam int unsigned AMP_Q_W   = 27;
	localparam logic [AMP_Q_W-1:0] AMP_ONE = 27'h400_0000;

	// reflectance full scale
	localparam logic [15:0] REFL_MAX = 16'hFFFF;

endpackage

### hw/rtl/fdr_div_pipe.sv
`timescale 1ns / 1ps
// fdr_div_pipe: pipelined restoring divider, one quotient bit per stage
// caller guarantees the initial partial remainder is below the divisor; uses fdr_pkg

module fdr_div_pipe #(
	parameter int unsigned DEN_W = fdr_pkg::DCOS_DEN_W,
	parameter int unsigned Q_W   = fdr_pkg::DCOS_Q_W,
	parameter int unsigned SB_W  = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [DEN_W-1:0] in_rem,
	input  logic [Q_W-1:0]   in_low,
	input  logic [DEN_W-1:0] in_den,
	input  logic [SB_W-1:0]  in_sb,
	output logic             out_valid,
	output logic [Q_W-1:0]   out_quo,
	output logic [SB_W-1:0]  out_sb
);
	import fdr_pkg::*;

	logic               vld_s [1:Q_W];
	logic [DEN_W-1:0]   rem_s [1:Q_W];
	logic [Q_W-1:0]     low_s [1:Q_W];
	logic [DEN_W-1:0]   den_s [1:Q_W];
	logic [Q_W-1:0]     quo_s [1:Q_W];
	logic [SB_W-1:0]    sb_s  [1:Q_W];

	for (genvar i = 0; i < Q_W; i++) begin : g_stage
		logic             vld_in;
		logic [DEN_W-1:0] rem_in;
		logic [Q_W-1:0]   low_in;
		logic [DEN_W-1:0] den_in;
		logic [Q_W-1:0]   quo_in;
		logic [SB_W-1:0]  sb_in;
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   diff;
		logic             ge;
		logic [Q_W-1:0]   quo_nx;
		logic [DEN_W-1:0] rem_nx;

		// stage zero is the input beat itself
		if (i == 0) begin : g_head
			assign vld_in = in_valid;
			assign rem_in = in_rem;
			assign low_in = in_low;
			assign den_in = in_den;
			assign quo_in = '0;
			assign sb_in  = in_sb;
		end else begin : g_body
			assign vld_in = vld_s[i];
			assign rem_in = rem_s[i];
			assign low_in = low_s[i];
			assign den_in = den_s[i];
			assign quo_in = quo_s[i];
			assign sb_in  = sb_s[i];
		end

		// shift in the next dividend bit and try a subtract
		assign trial = {rem_in, low_in[Q_W-1-i]};
		assign diff  = trial - {1'b0, den_in};
		assign ge    = trial >= {1'b0, den_in};
		assign rem_nx = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

		always_comb begin
			quo_nx = quo_in;
			quo_nx[Q_W-1-i] = ge;
		end

		// valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_in;
			end
		end

		// payload
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= rem_nx;
				low_s[i+1] <= low_in;
				den_s[i+1] <= den_in;
				quo_s[i+1] <= quo_nx;
				sb_s[i+1]  <= sb_in;
			end
		end
	end

	assign out_valid = vld_s[Q_W];
	assign out_quo   = quo_s[Q_W];
	assign out_sb    = sb_s[Q_W];

endmodule

### hw/rtl/fdr_sqrt_pipe.sv
`timescale 1ns / 1ps
// fdr_sqrt_pipe: pipelined digit-by-digit integer square root, one root bit per stage
// floor of the root of a 2*R_W bit radicand; uses fdr_pkg

module fdr_sqrt_pipe #(
	parameter int unsigned R_W  = fdr_pkg::SQRT_W,
	parameter int unsigned SB_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [2*R_W-1:0]  in_rad,
	input  logic [SB_W-1:0]   in_sb,
	output logic              out_valid,
	output logic [R_W-1:0]    out_root,
	output logic [SB_W-1:0]   out_sb
);
	import fdr_pkg::*;

	logic               vld_s  [1:R_W];
	logic [R_W:0]       rem_s  [1:R_W];
	logic [R_W-1:0]     root_s [1:R_W];
	logic [2*R_W-1:0]   rad_s  [1:R_W];
	logic [SB_W-1:0]    sb_s   [1:R_W];

	for (genvar i = 0; i < R_W; i++) begin : g_stage
		logic             vld_in;
		logic [R_W:0]     rem_in;
		logic [R_W-1:0]   root_in;
		logic [2*R_W-1:0] rad_in;
		logic [SB_W-1:0]  sb_in;
		logic [R_W+2:0]   trial;
		logic [R_W+2:0]   tst;
		logic [R_W+2:0]   diff;
		logic             ge;

		// stage zero starts from an empty root and remainder
		if (i == 0) begin : g_head
			assign vld_in  = in_valid;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = in_rad;
			assign sb_in   = in_sb;
		end else begin : g_body
			assign vld_in  = vld_s[i];
			assign rem_in  = rem_s[i];
			assign root_in = root_s[i];
			assign rad_in  = rad_s[i];
			assign sb_in   = sb_s[i];
		end

		// bring down the next bit pair and test root*4+1
		assign trial = {rem_in, rad_in[2*(R_W-1-i)+1], rad_in[2*(R_W-1-i)]};
		assign tst   = {1'b0, root_in, 2'b01};
		assign diff  = trial - tst;
		assign ge    = trial >= tst;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? diff[R_W:0] : trial[R_W:0];
				root_s[i+1] <= {root_in[R_W-2:0], ge};
				rad_s[i+1]  <= rad_in;
				sb_s[i+1]   <= sb_in;
			end
		end
	end

	assign out_valid = vld_s[R_W];
	assign out_root  = root_s[R_W];
	assign out_sb    = sb_s[R_W];

endmodule

### hw/rtl/fresnel_dielectric_reflectance.sv
`timescale 1ns / 1ps
// fresnel_dielectric_reflectance: top level of the unpolarized fresnel pipeline
// uses fdr_pkg, fdr_div_pipe and fdr_sqrt_pipe
//
// Usage: one ray hit per input beat (direction, normal, two q2.14 indices) and
// one result beat (q0.16 reflectance, entering, total_reflection) per hit, in
// order. Both channels are valid/ready; a beat moves when both are high.
// Each hit passes through these register stages in order: five arithmetic
// stages, 31 stages of the transmitted-cosine divider (one quotient bit each),
// 31 stages of the square root (one root bit each), two amplitude stages, 27
// stages of the two parallel ratio dividers, one squaring stage and the output
// register. Throughput is one hit per cycle while out_ready stays high.
// All stages advance together. When the receiver stalls, the output register
// holds its beat and one more result drops into a skid register; only then
// does in_ready fall and the whole pipeline freeze, losing nothing.
// Reset (arst_n low) empties every stage and the output; no results are left.

module fresnel_dielectric_reflectance (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] dir_x,
	input  logic [15:0] dir_y,
	input  logic [15:0] dir_z,
	input  logic [15:0] norm_x,
	input  logic [15:0] norm_y,
	input  logic [15:0] norm_z,
	input  logic [15:0] index_outside,
	input  logic [15:0] index_inside,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] reflectance,
	output logic        entering,
	output logic        total_reflection
);
	import fdr_pkg::*;

	localparam int unsigned SB1_W = 2 + 16 + 16 + ONE_Q30_W;

	logic en;

	// stage 1: component products
	logic               vld_s1;
	logic signed [31:0] px_s1, py_s1, pz_s1;
	logic [15:0]        n1_s1, n2_s1;

	// stage 2: dot product, clamp, swap
	logic signed [33:0] dot;
	logic signed [33:0] dot_cl;
	logic               ent_nx;
	logic [30:0]        c_nx;
	logic               vld_s2;
	logic [30:0]        c_s2;
	logic [15:0]        n1_s2, n2_s2;
	logic               ent_s2;

	// stage 3: squares
	logic               vld_s3;
	logic [61:0]        csq_s3;
	logic [31:0]        n1sq_s3, n2sq_s3;
	logic [30:0]        c_s3;
	logic [15:0]        n1_s3, n2_s3;
	logic               ent_s3;

	// stage 4: sine squared times n1 squared
	logic [30:0]        s2v;
	logic               vld_s4;
	logic [62:0]        prod_s4;
	logic [31:0]        n2sq_s4;
	logic [30:0]        c_s4;
	logic [15:0]        n1_s4, n2_s4;
	logic               ent_s4;

	// stage 5: total reflection test and dividend
	logic [61:0]        n2sh;
	logic               vld_s5;
	logic [61:0]        num_s5;
	logic [31:0]        n2sq_s5;
	logic               tir_s5;
	logic [30:0]        c_s5;
	logic [15:0]        n1_s5, n2_s5;
	logic               ent_s5;

	// divider and square root links
	logic               dv_valid;
	logic [DCOS_Q_W-1:0] dv_quo;
	logic [SB1_W-1:0]   dv_sb;
	logic [30:0]        d_cl;
	logic               sq_valid;
	logic [SQRT_W-1:0]  sq_root;
	logic [SB1_W-1:0]   sq_sb;
	logic [30:0]        sq_c;
	logic [15:0]        sq_n1, sq_n2;
	logic               sq_ent, sq_tir;
	logic [20:0]        c20, ct20;

	// stage 6: amplitude numerators
	logic               vld_s6;
	logic [36:0]        ap_s6, bp_s6, as_s6, bs_s6;
	logic               ent_s6, tir_s6;

	// stage 7: sums and differences
	logic               vld_s7;
	logic [37:0]        denp_s7, dens_s7;
	logic [36:0]        difp_s7, difs_s7;
	logic               zp_s7, zs_s7;
	logic               ent_s7, tir_s7;

	// ratio dividers
	logic               rp_valid, rs_valid;
	logic [AMP_Q_W-1:0] rp_quo, rs_quo;
	logic [2:0]         rp_sb;
	logic [0:0]         rs_sb;
	logic [AMP_Q_W-1:0] rp, rs;

	// stage 8: squared ratios
	logic               vld_s8;
	logic [53:0]        rpsq_s8, rssq_s8;
	logic               ent_s8, tir_s8;

	// result and output side
	logic [54:0]        sum;
	logic [54:0]        sum_rnd;
	logic [17:0]        refl_w;
	logic [15:0]        res_refl;
	logic               out_valid_q, sk_valid_q;
	logic [15:0]        out_refl_q, sk_refl_q;
	logic               out_ent_q, sk_ent_q, out_tir_q, sk_tir_q;

	// pipeline advances while the skid register is free
	assign en       = !sk_valid_q;
	assign in_ready = en;

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= $signed(dir_x) * $signed(norm_x);
			py_s1 <= $signed(dir_y) * $signed(norm_y);
			pz_s1 <= $signed(dir_z) * $signed(norm_z);
			n1_s1 <= index_outside;
			n2_s1 <= index_inside;
		end
	end

	// stage 2: sum, clamp to plus or minus one, fold leaving rays
	always_comb begin
		dot = 34'(px_s1) + 34'(py_s1) + 34'(pz_s1);
		if (dot > $signed({4'b0, ONE_Q30[29:0] | 30'h0} + 34'h4000_0000)) begin
			dot_cl = 34'sh4000_0000;
		end else if (dot < -34'sh4000_0000) begin
			dot_cl = -34'sh4000_0000;
		end else begin
			dot_cl = dot;
		end
		ent_nx = dot_cl > 34'sd0;
		if (ent_nx) begin
			c_nx = dot_cl[30:0];
		end else begin
			c_nx = 31'(-dot_cl);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s2   <= c_nx;
			ent_s2 <= ent_nx;
			n1_s2  <= ent_nx ? n1_s1 : n2_s1;
			n2_s2  <= ent_nx ? n2_s1 : n1_s1;
		end
	end

	// stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			csq_s3  <= 62'(c_s2) * 62'(c_s2);
			n1sq_s3 <= 32'(n1_s2) * 32'(n1_s2);
			n2sq_s3 <= 32'(n2_s2) * 32'(n2_s2);
			c_s3    <= c_s2;
			n1_s3   <= n1_s2;
			n2_s3   <= n2_s2;
			ent_s3  <= ent_s2;
		end
	end

	// stage 4
	assign s2v = ONE_Q30 - csq_s3[60:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s4 <= 63'(n1sq_s3) * 63'(s2v);
			n2sq_s4 <= n2sq_s3;
			c_s4    <= c_s3;
			n1_s4   <= n1_s3;
			n2_s4   <= n2_s3;
			ent_s4  <= ent_s3;
		end
	end

	// stage 5
	assign n2sh = {n2sq_s4, 30'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tir_s5  <= prod_s4 >= {1'b0, n2sh};
			num_s5  <= n2sh - prod_s4[61:0];
			n2sq_s5 <= n2sq_s4;
			c_s5    <= c_s4;
			n1_s5   <= n1_s4;
			n2_s5   <= n2_s4;
			ent_s5  <= ent_s4;
		end
	end

	// transmitted cosine squared
	fdr_div_pipe #(
		.DEN_W (DCOS_DEN_W),
		.Q_W   (DCOS_Q_W),
		.SB_W  (SB1_W)
	) u_div_dcos (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s5),
		.in_rem    ({1'b0, num_s5[61:31]}),
		.in_low    (num_s5[30:0]),
		.in_den    (n2sq_s5),
		.in_sb     ({ent_s5, tir_s5, n1_s5, n2_s5, c_s5}),
		.out_valid (dv_valid),
		.out_quo   (dv_quo),
		.out_sb    (dv_sb)
	);

	assign d_cl = (dv_quo > ONE_Q30) ? ONE_Q30 : dv_quo;

	// transmitted cosine
	fdr_sqrt_pipe #(
		.R_W  (SQRT_W),
		.SB_W (SB1_W)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dv_valid),
		.in_rad    ({1'b0, d_cl, 30'b0}),
		.in_sb     (dv_sb),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_sb    (sq_sb)
	);

	assign {sq_ent, sq_tir, sq_n1, sq_n2, sq_c} = sq_sb;
	assign c20  = sq_c[30:10];
	assign ct20 = sq_root[30:10];

	// stage 6
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ap_s6  <= 37'(sq_n2) * 37'(c20);
			bp_s6  <= 37'(sq_n1) * 37'(ct20);
			as_s6  <= 37'(sq_n1) * 37'(c20);
			bs_s6  <= 37'(sq_n2) * 37'(ct20);
			ent_s6 <= sq_ent;
			tir_s6 <= sq_tir;
		end
	end

	// stage 7
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			denp_s7 <= 38'(ap_s6) + 38'(bp_s6);
			dens_s7 <= 38'(as_s6) + 38'(bs_s6);
			difp_s7 <= (ap_s6 > bp_s6) ? ap_s6 - bp_s6 : bp_s6 - ap_s6;
			difs_s7 <= (as_s6 > bs_s6) ? as_s6 - bs_s6 : bs_s6 - as_s6;
			zp_s7   <= (ap_s6 == '0) && (bp_s6 == '0);
			zs_s7   <= (as_s6 == '0) && (bs_s6 == '0);
			ent_s7  <= ent_s6;
			tir_s7  <= tir_s6;
		end
	end

	// amplitude ratios, parallel and perpendicular
	fdr_div_pipe #(
		.DEN_W (AMP_DEN_W),
		.Q_W   (AMP_Q_W),
		.SB_W  (3)
	) u_div_par (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s7),
		.in_rem    ({2'b0, difp_s7[36:1]}),
		.in_low    ({difp_s7[0], 26'b0}),
		.in_den    (denp_s7),
		.in_sb     ({ent_s7, tir_s7, zp_s7}),
		.out_valid (rp_valid),
		.out_quo   (rp_quo),
		.out_sb    (rp_sb)
	);

	fdr_div_pipe #(
		.DEN_W (AMP_DEN_W),
		.Q_W   (AMP_Q_W),
		.SB_W  (1)
	) u_div_perp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s7),
		.in_rem    ({2'b0, difs_s7[36:1]}),
		.in_low    ({difs_s7[0], 26'b0}),
		.in_den    (dens_s7),
		.in_sb     (zs_s7),
		.out_valid (rs_valid),
		.out_quo   (rs_quo),
		.out_sb    (rs_sb)
	);

	// zero denominator reads as unit amplitude
	assign rp = rp_sb[0] ? AMP_ONE : rp_quo;
	assign rs = rs_sb[0] ? AMP_ONE : rs_quo;

	// stage 8
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= rp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rpsq_s8 <= 54'(rp) * 54'(rp);
			rssq_s8 <= 54'(rs) * 54'(rs);
			ent_s8  <= rp_sb[2];
			tir_s8  <= rp_sb[1];
		end
	end

	// mean of squares, rounded half up, saturated; full scale on total reflection
	always_comb begin
		sum     = 55'(rpsq_s8) + 55'(rssq_s8);
		sum_rnd = sum + 55'(64'h10_0000_0000);
		refl_w  = sum_rnd[54:37];
		if (tir_s8 || (refl_w > 18'(REFL_MAX))) begin
			res_refl = REFL_MAX;
		end else begin
			res_refl = refl_w[15:0];
		end
	end

	// output register with skid beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sk_valid_q  <= 1'b0;
		end else if (out_valid_q && !out_ready) begin
			if (en && vld_s8) begin
				sk_valid_q <= 1'b1;
			end
		end else if (sk_valid_q) begin
			out_valid_q <= 1'b1;
			sk_valid_q  <= 1'b0;
		end else begin
			out_valid_q <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && !out_ready) begin
			if (en) begin
				sk_refl_q <= res_refl;
				sk_ent_q  <= ent_s8;
				sk_tir_q  <= tir_s8;
			end
		end else if (sk_valid_q) begin
			out_refl_q <= sk_refl_q;
			out_ent_q  <= sk_ent_q;
			out_tir_q  <= sk_tir_q;
		end else begin
			out_refl_q <= res_refl;
			out_ent_q  <= ent_s8;
			out_tir_q  <= tir_s8;
		end
	end

	assign out_valid        = out_valid_q;
	assign reflectance      = out_refl_q;
	assign entering         = out_ent_q;
	assign total_reflection = out_tir_q;

`ifndef SYNTHESIS
	// a totally reflected hit always reports full scale
	a_tir_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && total_reflection |-> reflectance == REFL_MAX)
		else $error("total reflection without full scale reflectance");

	// skid beat only exists behind a held output beat
	a_skid_behind: assert property (@(posedge clk) disable iff (!arst_n)
		sk_valid_q |-> out_valid_q)
		else $error("skid register full while output empty");

	// skid fills only when the receiver stalled a beat
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_valid_q) |-> $past(out_valid_q && !out_ready))
		else $error("skid register filled without a stall");

	// both ratio dividers stay in lockstep
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		rp_valid == rs_valid)
		else $error("ratio dividers out of step");
`endif

endmodule

### test/tb_fresnel_dielectric_reflectance.sv
`timescale 1ns / 1ps
// tb_fresnel_dielectric_reflectance: self-checking bench for the fresnel reflectance pipeline
// drives random and directed ray hits and checks every result beat against its own predictor
// depends on fresnel_dielectric_reflectance only

module tb_fresnel_dielectric_reflectance;

	localparam int unsigned LATENCY   = 98;
	localparam int unsigned WDOG_MAX  = 4000;
	localparam int unsigned N_RANDOM  = 800;
	localparam logic [63:0] Q30_ONE   = 64'd1 << 30;

	typedef struct packed {
		logic [15:0] refl;
		logic        ent;
		logic        tir;
	} fresnel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic [15:0] norm_x = '0, norm_y = '0, norm_z = '0;
	logic [15:0] index_outside = 16'h4000, index_inside = 16'h4000;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] reflectance;
	logic        entering;
	logic        total_reflection;

	fresnel_t    pending_refl[$];
	int          n_errors = 0;
	int          idle_cycles = 0;
	bit          no_idle = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	fresnel_dielectric_reflectance DUT (.*);

	// integer square root, bit by bit
	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] b;
		root = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v = v - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	// |a-b|/(a+b) in q.26, zero denominator taken as one
	function automatic logic [63:0] amp_q26(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] diff;
		if (a + b == 0) return 64'd1 << 26;
		diff = (a > b) ? a - b : b - a;
		return (diff << 26) / (a + b);
	endfunction

	function automatic fresnel_t fresnel_of(input logic [15:0] dx, dy, dz, nx, ny, nz,
			input logic [15:0] ni, no);
		longint      dp;
		logic [63:0] n1, n2, cosi, sin2, d, ct, rp, rs, sum, nn2;
		fresnel_t    r;
		dp = longint'($signed(dx)) * longint'($signed(nx))
			+ longint'($signed(dy)) * longint'($signed(ny))
			+ longint'($signed(dz)) * longint'($signed(nz));
		if (dp > longint'(Q30_ONE)) dp = longint'(Q30_ONE);
		if (dp < -longint'(Q30_ONE)) dp = -longint'(Q30_ONE);
		r.ent = dp > 0;
		// leaving hits swap the media
		n1 = r.ent ? {48'd0, ni} : {48'd0, no};
		n2 = r.ent ? {48'd0, no} : {48'd0, ni};
		cosi = r.ent ? 64'(dp) : 64'(-dp);
		sin2 = Q30_ONE - ((cosi * cosi) >> 30);
		r.tir = (n1 * n1 * sin2) >= (n2 * n2 * Q30_ONE);
		if (r.tir) begin
			r.refl = 16'hFFFF;
		end else begin
			nn2 = n2 * n2;
			d = (nn2 * Q30_ONE - n1 * n1 * sin2) / nn2;
			if (d > Q30_ONE) d = Q30_ONE;
			ct = isqrt(d << 30);
			rp = amp_q26(n2 * (cosi >> 10), n1 * (ct >> 10));
			rs = amp_q26(n1 * (cosi >> 10), n2 * (ct >> 10));
			sum = (rp * rp + rs * rs + (64'd1 << 36)) >> 37;
			r.refl = (sum > 64'hFFFF) ? 16'hFFFF : sum[15:0];
		end
		return r;
	endfunction

	// send one hit; valid stays high between back-to-back beats
	task automatic send_hit(input logic [15:0] dx, dy, dz, nx, ny, nz, ni, no);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		dir_x = dx; dir_y = dy; dir_z = dz;
		norm_x = nx; norm_y = ny; norm_z = nz;
		index_outside = ni; index_inside = no;
		do @(posedge clk); while (!in_ready);
		pending_refl.insert(pending_refl.size(), fresnel_of(dx, dy, dz, nx, ny, nz, ni, no));
		@(negedge clk);
	endtask

	// a component whose size spreads over many octaves
	function automatic logic [15:0] rand_comp();
		logic [15:0] v;
		v = 16'($urandom);
		return 16'($signed(v) >>> $urandom_range(0, 9));
	endfunction

	function automatic logic [15:0] rand_index();
		if ($urandom_range(0, 3) == 0) return 16'($urandom_range(1, 65535));
		return 16'($urandom_range(16384, 40960));
	endfunction

	task automatic test_directed();
		// head-on entering, glass and water
		send_hit(16'h7FFF, 0, 0, 16'h7FFF, 0, 0, 16'h4000, 16'h6000);
		send_hit(0, 16'h8000, 0, 0, 16'h8000, 0, 16'h4000, 16'h5555);
		// leaving head-on
		send_hit(16'h7FFF, 0, 0, 16'h8000, 0, 0, 16'h4000, 16'h6000);
		// grazing hit, dot zero
		send_hit(16'h7FFF, 0, 0, 0, 16'h7FFF, 0, 16'h4000, 16'h6000);
		send_hit(0, 0, 0, 0, 0, 0, 16'h6000, 16'h4000);
		// total internal reflection on a shallow leaving ray
		send_hit(16'h7000, 16'h1000, 0, 16'hF000, 0, 0, 16'h4000, 16'h6000);
		// unnormalized vectors saturate the dot product
		send_hit(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h4000, 16'h6000);
		send_hit(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h6000, 16'h4000);
		send_hit(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'h0001);
		// extreme and zero indices
		send_hit(16'h5A82, 16'h5A82, 0, 0, 16'h7FFF, 0, 16'hFFFF, 16'hFFFF);
		send_hit(16'h5A82, 16'h5A82, 0, 0, 16'h7FFF, 0, 16'h0001, 16'hFFFF);
		send_hit(16'h5A82, 16'h5A82, 0, 0, 16'h7FFF, 0, 16'hFFFF, 16'h0001);
		send_hit(16'h5A82, 16'h5A82, 0, 0, 16'h7FFF, 0, 16'h0000, 16'h4000);
		send_hit(16'h5A82, 16'h5A82, 0, 0, 16'h7FFF, 0, 16'h4000, 16'h0000);
		send_hit(16'h5A82, 16'h5A82, 0, 0, 16'h8000, 0, 16'h4000, 16'h0000);
		send_hit(0, 0, 16'h0001, 0, 0, 16'h0001, 16'h0000, 16'h0000);
		// equal indices, no interface
		send_hit(16'h2000, 16'h3000, 16'h4000, 16'h1000, 16'h2000, 16'h3000, 16'h5000, 16'h5000);
	endtask

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++) begin
			// each stretch of 100 hits runs with or without idling, chosen at random
			if (i % 100 == 0) no_idle = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 7) == 0)
				send_hit(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			else
				send_hit(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
					rand_comp(), rand_index(), rand_index());
		end
		no_idle = 0;
	endtask

	task automatic test_drain_pause();
		in_valid = 1'b0;
		wait (pending_refl.size() == 0);
		@(negedge clk);
		for (int i = 0; i < 20; i++)
			send_hit(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
				rand_comp(), rand_index(), rand_index());
	endtask

	// receiver stalls
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = no_idle ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall - 1) @(negedge clk);
				@(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	// result check
	always @(posedge clk) begin
		fresnel_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_refl.size() == 0) begin
				$error("result beat with nothing expected");
				n_errors++;
			end else begin
				want = pending_refl.pop_front();
				if (reflectance !== want.refl) begin
					$error("reflectance expected %0d got %0d", want.refl, reflectance);
					n_errors++;
				end
				if (entering !== want.ent) begin
					$error("entering expected %0d got %0d", want.ent, entering);
					n_errors++;
				end
				if (total_reflection !== want.tir) begin
					$error("total_reflection expected %0d got %0d", want.tir,
						total_reflection);
					n_errors++;
				end
			end
		end
	end

	// watchdog on cycles with no beat moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_drain_pause();
		test_random(N_RANDOM);
		in_valid = 1'b0;
		wait (pending_refl.size() == 0);
		repeat (LATENCY + 12) @(posedge clk);
		if (n_errors == 0 && pending_refl.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### fresnel_dielectric_reflectance.f
hw/rtl/fdr_pkg.sv
hw/rtl/fdr_div_pipe.sv
hw/rtl/fdr_sqrt_pipe.sv
hw/rtl/fresnel_dielectric_reflectance.sv
test/tb_fresnel_dielectric_reflectance.sv
